[hdl/assert_macros.svh]
// Assertion macros shared by the tokenizer RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[hdl/argtok_pkg.sv]
// Types, character codes and helpers for the argument tokenizer.
// No dependencies.
package argtok_pkg;

  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_END      = 3'd1;
  localparam logic [2:0] KIND_REDELIM  = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  localparam logic ERR_TOO_MANY  = 1'b0;
  localparam logic ERR_DOUBLE_WS = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  localparam logic [8:0] NO_DELIM = 9'h100;

  localparam int RES_PER_REQ = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SKIP,
    PH_BODY,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    IGN_OFF,
    IGN_COMMENT,
    IGN_ERROR
  } ign_t;

  typedef struct packed {
    logic [7:0] cur_idx;
    logic       in_q;
    logic [8:0] prev_d;
    logic       esc;
    logic       oct_act;
    logic [7:0] oct_val;
    phase_t     phase;
    logic       has_data;
    ign_t       ign;
  } tok_st_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] idx;
    logic [7:0] delim;
    logic       key;
    logic       err;
  } res_t;

  typedef struct packed {
    logic [1:0]                  cnt;
    res_t [RES_PER_REQ-1:0]      res;
  } bundle_t;

  localparam tok_st_t ST_START = '{
    cur_idx:  8'd0,
    in_q:     1'b0,
    prev_d:   NO_DELIM,
    esc:      1'b0,
    oct_act:  1'b0,
    oct_val:  8'd0,
    phase:    PH_IDLE,
    has_data: 1'b0,
    ign:      IGN_OFF
  };

  function automatic logic is_ws(logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_LF, CH_CR, CH_COMMA,
                     CH_SEMI, CH_HASH, CH_COLON, CH_SLASH, CH_PIPE};
  endfunction

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] data, logic [7:0] idx,
                                  logic [7:0] delim, logic key, logic err);
    res_t r;
    r.kind  = kind;
    r.data  = data;
    r.idx   = idx;
    r.delim = delim;
    r.key   = key;
    r.err   = err;
    return r;
  endfunction

  function automatic tok_st_t take_byte(tok_st_t s, logic [7:0] b);
    tok_st_t t;
    t = s;
    if (t.phase == PH_BODY) begin
      t.phase    = PH_DATA;
      t.has_data = (b != CH_NUL);
    end
    t.prev_d = NO_DELIM;
    return t;
  endfunction

endpackage

[hdl/argument_tokenizer.sv]
// Argument tokenizer top level: per-character decode and result queue.
// Depends on argtok_pkg and assert_macros.svh.
//
// Takes one character per cycle unless stalled; each request is decoded in
// the cycle it is accepted and yields zero to three results (a data byte,
// a field end, a redelimit, done or error), which queue as one bundle in a
// four-deep buffer and leave one per cycle unless out_stall is high. A
// stream with at most one result per character runs at one character per
// clock; characters with more results fill the buffer, and in_stall rises
// only when all four slots are full. Write field_limit only while idle.
`include "assert_macros.svh"

module argument_tokenizer
  import argtok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_field_index,
  output logic [7:0] out_delimiter,
  output logic       out_is_key,
  output logic       out_error_code,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0]       field_limit_r;
  tok_st_t          st_r, st_nxt;
  bundle_t          fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   fifo_cnt_r;
  logic [1:0]       sub_r;

  logic             in_acc, out_acc, push, pop;
  logic [1:0]       n;
  res_t [RES_PER_REQ-1:0] res;
  bundle_t          head;
  res_t             cur_res;

  logic [7:0]       c;
  logic             go, redelim, dbl_ws;
  logic signed [9:0] lim_m2;
  logic [7:0]       bval;

  assign c      = in_char_code;
  assign lim_m2 = $signed({2'b00, field_limit_r}) - 10'sd2;

  always_comb begin
    st_nxt  = st_r;
    n       = 2'd0;
    res     = '0;
    go      = 1'b1;
    redelim = 1'b0;
    dbl_ws  = 1'b0;
    bval    = c;
    if (c == CH_NUL) begin
      st_nxt.esc = 1'b0;
      if (st_nxt.oct_act && st_nxt.ign == IGN_OFF) begin
        st_nxt.oct_act = 1'b0;
        res[n] = mk_res(KIND_DATA, st_nxt.oct_val, st_nxt.cur_idx, CH_NUL, 1'b0, 1'b0);
        n      = n + 2'd1;
        st_nxt = take_byte(st_nxt, st_nxt.oct_val);
      end
      if (st_nxt.ign == IGN_ERROR) begin
        n = 2'd0;
      end else begin
        if (st_nxt.ign == IGN_OFF && st_nxt.phase != PH_IDLE) begin
          if (!st_nxt.has_data && (st_nxt.prev_d == {1'b0, CH_SEMI} ||
                                   st_nxt.prev_d == {1'b0, CH_HASH})) begin
            st_nxt.ign = IGN_COMMENT;
          end else begin
            res[n] = mk_res(KIND_END, CH_NUL, st_nxt.cur_idx, CH_NUL, 1'b0, 1'b0);
            n      = n + 2'd1;
            st_nxt.cur_idx = st_nxt.cur_idx + 8'd1;
            st_nxt.phase   = PH_IDLE;
          end
        end
        res[n] = mk_res(KIND_DONE, CH_NUL, st_nxt.cur_idx, CH_NUL, 1'b0, 1'b0);
        n      = n + 2'd1;
      end
      st_nxt = ST_START;
    end else if (st_r.ign != IGN_OFF) begin
      n = 2'd0;
    end else if (st_r.esc) begin
      st_nxt.esc = 1'b0;
      if (is_octal(c)) begin
        st_nxt.oct_act = 1'b1;
        st_nxt.oct_val = {5'd0, c[2:0]};
        st_nxt.prev_d  = NO_DELIM;
      end else begin
        case (c)
          CH_LO_R: bval = CH_CR;
          CH_LO_N: bval = CH_LF;
          CH_LO_B: bval = CH_BS;
          CH_LO_F: bval = CH_FF;
          default: bval = c;
        endcase
        res[n] = mk_res(KIND_DATA, bval, st_nxt.cur_idx, CH_NUL, 1'b0, 1'b0);
        n      = n + 2'd1;
        st_nxt = take_byte(st_nxt, bval);
      end
    end else begin
      if (st_nxt.oct_act) begin
        if (is_octal(c)) begin
          st_nxt.oct_val = {st_nxt.oct_val[4:0], c[2:0]};
          go = 1'b0;
        end else begin
          st_nxt.oct_act = 1'b0;
          res[n] = mk_res(KIND_DATA, st_nxt.oct_val, st_nxt.cur_idx, CH_NUL, 1'b0, 1'b0);
          n      = n + 2'd1;
          st_nxt = take_byte(st_nxt, st_nxt.oct_val);
        end
      end
      if (go && st_nxt.phase == PH_IDLE) begin
        if ($signed({2'b00, st_nxt.cur_idx}) >= lim_m2) begin
          st_nxt.ign = IGN_ERROR;
          res[n] = mk_res(KIND_ERROR, CH_NUL, 8'd0, CH_NUL, 1'b0, ERR_TOO_MANY);
          n      = n + 2'd1;
          go     = 1'b0;
        end else begin
          st_nxt.phase    = PH_SKIP;
          st_nxt.in_q     = 1'b0;
          st_nxt.has_data = 1'b0;
        end
      end
      if (go && st_nxt.phase == PH_SKIP) begin
        if (is_ws(c)) begin
          go = 1'b0;
        end else begin
          st_nxt.phase = PH_BODY;
        end
      end
      if (go) begin
        if (c == CH_QUOTE) begin
          st_nxt.in_q   = ~st_nxt.in_q;
          st_nxt.prev_d = NO_DELIM;
        end else if (c == CH_BSL) begin
          st_nxt.esc    = 1'b1;
          st_nxt.prev_d = NO_DELIM;
        end else if ((c == CH_EQ || is_delim(c)) && st_nxt.in_q) begin
          res[n] = mk_res(KIND_DATA, c, st_nxt.cur_idx, CH_NUL, 1'b0, 1'b0);
          n      = n + 2'd1;
          st_nxt = take_byte(st_nxt, c);
        end else if (c == CH_EQ) begin
          res[n] = mk_res(KIND_END, CH_NUL, st_nxt.cur_idx + 8'd1, CH_EQ, 1'b1, 1'b0);
          n      = n + 2'd1;
          st_nxt.cur_idx = st_nxt.cur_idx + 8'd2;
          st_nxt.prev_d  = {1'b0, CH_EQ};
          st_nxt.phase   = PH_IDLE;
        end else if (is_delim(c)) begin
          if (st_nxt.prev_d != NO_DELIM && is_ws(st_nxt.prev_d[7:0])) begin
            if (is_ws(c)) begin
              dbl_ws = 1'b1;
            end else if (c != CH_SEMI && c != CH_HASH) begin
              redelim = 1'b1;
            end
          end
          if (dbl_ws) begin
            st_nxt.ign = IGN_ERROR;
            res[n] = mk_res(KIND_ERROR, CH_NUL, 8'd0, CH_NUL, 1'b0, ERR_DOUBLE_WS);
            n      = n + 2'd1;
          end else begin
            st_nxt.prev_d = {1'b0, c};
            if (redelim) begin
              st_nxt.phase = PH_IDLE;
              res[n] = mk_res(KIND_REDELIM, CH_NUL, st_nxt.cur_idx - 8'd1, c, 1'b0, 1'b0);
              n      = n + 2'd1;
            end else if (!st_nxt.has_data && (c == CH_SEMI || c == CH_HASH)) begin
              st_nxt.ign = IGN_COMMENT;
            end else begin
              res[n] = mk_res(KIND_END, CH_NUL, st_nxt.cur_idx, c, 1'b0, 1'b0);
              n      = n + 2'd1;
              st_nxt.cur_idx = st_nxt.cur_idx + 8'd1;
              st_nxt.phase   = PH_IDLE;
            end
          end
        end else begin
          res[n] = mk_res(KIND_DATA, c, st_nxt.cur_idx, CH_NUL, 1'b0, 1'b0);
          n      = n + 2'd1;
          st_nxt = take_byte(st_nxt, c);
        end
      end
    end
  end

  assign in_stall  = (fifo_cnt_r == (PTR_W+1)'(FIFO_DEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign push      = in_acc && (n != 2'd0);
  assign out_valid = (fifo_cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;
  assign head      = fifo_r[rd_ptr_r];
  assign cur_res   = head.res[sub_r];
  assign out_last  = (sub_r == head.cnt - 2'd1);
  assign pop       = out_acc && out_last;

  assign out_kind        = cur_res.kind;
  assign out_data_byte   = cur_res.data;
  assign out_field_index = cur_res.idx;
  assign out_delimiter   = cur_res.delim;
  assign out_is_key      = cur_res.key;
  assign out_error_code  = cur_res.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_limit_r <= 8'd255;
      st_r          <= ST_START;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      fifo_cnt_r    <= '0;
      sub_r         <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        field_limit_r <= cfg_wr_data;
      end
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
        sub_r    <= 2'd0;
      end else if (out_acc) begin
        sub_r <= sub_r + 2'd1;
      end
      if (push && !pop) begin
        fifo_cnt_r <= fifo_cnt_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        fifo_cnt_r <= fifo_cnt_r - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{cnt: n, res: res};
    end
  end

  `ASSERT_NEVER(a_fifo_over, clk, rst_n, fifo_cnt_r > (PTR_W+1)'(FIFO_DEPTH))
  `ASSERT_CLK(a_sub_in_range, clk, rst_n, out_valid |-> (head.cnt != 2'd0 && sub_r < head.cnt))
  `ASSERT_CLK(a_push_visible, clk, rst_n, push |=> out_valid)
  `ASSERT_CLK(a_nul_gives_done, clk, rst_n,
    (in_acc && in_char_code == CH_NUL && st_r.ign != IGN_ERROR) |->
      (n != 2'd0 && res[n - 2'd1].kind == KIND_DONE))

endmodule
